/* rtl/usd_pkg.sv */
// Shared types, codes and constants for the upload stream deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package usd_pkg;

    // Header layout and queue sizing
    localparam int unsigned USD_HDR_BYTES   = 12;
    localparam int unsigned USD_QUEUE_DEPTH = 4;

    // Register reset values
    localparam logic [31:0] USD_MAGIC_RESET      = 32'd0;
    localparam logic [15:0] USD_VERSION_RESET    = 16'd1;
    localparam logic [16:0] USD_MAX_PAY_RESET    = 17'd4096;
    localparam logic [15:0] USD_TYPE_BEGIN_RESET = 16'd1;
    localparam logic [15:0] USD_TYPE_CHUNK_RESET = 16'd2;
    localparam logic [15:0] USD_TYPE_END_RESET   = 16'd3;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_MAGIC      = 3'd0,
        REG_VERSION    = 3'd1,
        REG_MAX_PAY    = 3'd2,
        REG_TYPE_BEGIN = 3'd3,
        REG_TYPE_CHUNK = 3'd4,
        REG_TYPE_END   = 3'd5
    } usd_reg_t;

    // Deframer phase
    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_BEGIN_PAY = 3'd1,
        PH_CHUNK_HDR = 3'd2,
        PH_CHUNK_PAY = 3'd3,
        PH_END_HDR   = 3'd4
    } usd_phase_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_BEGUN    = 2'd1,
        KIND_COMPLETE = 2'd2,
        KIND_ERROR    = 2'd3
    } usd_kind_t;

    // Error codes
    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_MAGIC     = 3'd1,
        ERR_VERSION   = 3'd2,
        ERR_TOO_LONG  = 3'd3,
        ERR_TYPE      = 3'd4,
        ERR_CHUNK_LEN = 3'd5,
        ERR_BEGIN_LEN = 3'd6,
        ERR_END_LEN   = 3'd7
    } usd_err_t;

    // Register set seen by the front end
    typedef struct packed {
        logic [31:0] magic_word;
        logic [15:0] protocol_version;
        logic [16:0] max_payload;
        logic [15:0] type_begin;
        logic [15:0] type_chunk;
        logic [15:0] type_end;
    } usd_cfg_t;

    // Compact result item held in the queue; data is the byte or the size
    typedef struct packed {
        usd_kind_t   kind;
        logic [31:0] data;
        logic        last;
        usd_err_t    err;
    } usd_item_t;

endpackage

/* rtl/upload_stream_deframer.sv */
// Top level of the upload stream deframer: configuration registers and wiring.
// Depends on usd_pkg, usd_front, usd_queue and usd_back.
`timescale 1ns / 1ps

// The block takes one stream byte per cycle while in_ready is high and gives
// at most one result item per byte, in order: the front end checks headers
// and tracks the transfer, the result waits in a queue of QUEUE_DEPTH items
// and leaves through a registered output stage. in_ready stays high as long
// as the queue has room, so a sink that takes a result every cycle sees a
// sustained rate of one byte per cycle; in_ready falls only once QUEUE_DEPTH
// results are waiting behind a stalled sink. Register writes take effect at
// the next header check and should be made while no result is outstanding.
module upload_stream_deframer #(
    parameter int unsigned QUEUE_DEPTH = usd_pkg::USD_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  stream_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [7:0]  payload_byte,
    output logic        last_of_transfer,
    output logic [31:0] transfer_size,
    output logic [2:0]  error_code,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import usd_pkg::*;

    usd_cfg_t  cfg_reg;
    usd_item_t front_item;
    usd_item_t head_item;
    logic      take;
    logic      push;
    logic      pop;
    logic      head_valid;
    logic      full;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic_word       <= USD_MAGIC_RESET;
            cfg_reg.protocol_version <= USD_VERSION_RESET;
            cfg_reg.max_payload      <= USD_MAX_PAY_RESET;
            cfg_reg.type_begin       <= USD_TYPE_BEGIN_RESET;
            cfg_reg.type_chunk       <= USD_TYPE_CHUNK_RESET;
            cfg_reg.type_end         <= USD_TYPE_END_RESET;
        end
        else if (cfg_we)
        begin
            unique case (usd_reg_t'(cfg_index))
                REG_MAGIC:      cfg_reg.magic_word       <= cfg_data;
                REG_VERSION:    cfg_reg.protocol_version <= cfg_data[15:0];
                REG_MAX_PAY:    cfg_reg.max_payload      <= cfg_data[16:0];
                REG_TYPE_BEGIN: cfg_reg.type_begin       <= cfg_data[15:0];
                REG_TYPE_CHUNK: cfg_reg.type_chunk       <= cfg_data[15:0];
                REG_TYPE_END:   cfg_reg.type_end         <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Take a byte whenever the queue has room
    assign in_ready = !full;
    assign take     = in_valid && in_ready;

    usd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .take        (take),
        .stream_byte (stream_byte),
        .push        (push),
        .item        (front_item)
    );

    usd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (front_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item),
        .full       (full)
    );

    usd_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head_valid       (head_valid),
        .head_item        (head_item),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .result_kind      (result_kind),
        .payload_byte     (payload_byte),
        .last_of_transfer (last_of_transfer),
        .transfer_size    (transfer_size),
        .error_code       (error_code)
    );

endmodule

/* rtl/usd_front.sv */
// Front end: takes stream bytes, collects and checks headers, tracks the transfer.
// Depends on usd_pkg; pushes classified result items into usd_queue.
`timescale 1ns / 1ps

module usd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  usd_pkg::usd_cfg_t cfg,
    input  logic             take,
    input  logic [7:0]       stream_byte,
    output logic             push,
    output usd_pkg::usd_item_t item
);
    import usd_pkg::*;

    localparam logic [3:0] HDR_LAST = 4'(USD_HDR_BYTES - 1);

    usd_phase_t  phase_reg, phase_next;
    logic [3:0]  header_index_reg, header_index_next;
    logic [31:0] magic_reg, magic_next;
    logic [15:0] version_reg, version_next;
    logic [15:0] type_reg, type_next;
    logic [23:0] length_reg, length_next;
    logic [16:0] payload_left_reg, payload_left_next;
    logic [31:0] transfer_left_reg, transfer_left_next;

    logic        hdr_last;
    logic [31:0] length_full;
    logic [31:0] size_shift;
    logic        pay_last;
    usd_err_t    hdr_err;

    // Header and counter conditions for the current byte
    assign hdr_last    = (header_index_reg == HDR_LAST);
    assign length_full = {length_reg, stream_byte};
    assign size_shift  = {transfer_left_reg[23:0], stream_byte};
    assign pay_last    = (payload_left_reg == 17'd1);

    // Check the completed header; the first failure wins
    always_comb
    begin
        hdr_err = ERR_NONE;
        if (magic_reg != cfg.magic_word)
        begin
            hdr_err = ERR_MAGIC;
        end
        else if (version_reg != cfg.protocol_version)
        begin
            hdr_err = ERR_VERSION;
        end
        else if (length_full > {15'd0, cfg.max_payload})
        begin
            hdr_err = ERR_TOO_LONG;
        end
        else if (phase_reg == PH_CHUNK_HDR)
        begin
            if (type_reg != cfg.type_chunk)
                hdr_err = ERR_TYPE;
            else if (length_full == 32'd0 || length_full > transfer_left_reg)
                hdr_err = ERR_CHUNK_LEN;
        end
        else if (phase_reg == PH_END_HDR)
        begin
            if (type_reg != cfg.type_end)
                hdr_err = ERR_TYPE;
            else if (length_full != 32'd0)
                hdr_err = ERR_END_LEN;
        end
        else
        begin
            if (type_reg != cfg.type_begin)
                hdr_err = ERR_TYPE;
            else if (length_full != 32'd4)
                hdr_err = ERR_BEGIN_LEN;
        end
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            unique case (phase_reg) inside
                PH_BEGIN_PAY:
                begin
                    if (pay_last)
                        phase_next = (size_shift == 32'd0) ? PH_END_HDR : PH_CHUNK_HDR;
                end
                PH_CHUNK_PAY:
                begin
                    if (pay_last)
                        phase_next = (transfer_left_reg == 32'd1) ? PH_END_HDR
                                                                  : PH_CHUNK_HDR;
                end
                PH_IDLE, PH_CHUNK_HDR, PH_END_HDR:
                begin
                    if (hdr_last)
                    begin
                        if (hdr_err != ERR_NONE)
                            phase_next = PH_IDLE;
                        else if (phase_reg == PH_CHUNK_HDR)
                            phase_next = PH_CHUNK_PAY;
                        else if (phase_reg == PH_END_HDR)
                            phase_next = PH_IDLE;
                        else
                            phase_next = PH_BEGIN_PAY;
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // Datapath updates and result items
    always_comb
    begin
        header_index_next  = header_index_reg;
        magic_next         = magic_reg;
        version_next       = version_reg;
        type_next          = type_reg;
        length_next        = length_reg;
        payload_left_next  = payload_left_reg;
        transfer_left_next = transfer_left_reg;
        push               = 1'b0;
        item.kind          = KIND_PAYLOAD;
        item.data          = 32'd0;
        item.last          = 1'b0;
        item.err           = ERR_NONE;
        if (take)
        begin
            unique case (phase_reg) inside
                PH_BEGIN_PAY:
                begin
                    transfer_left_next = size_shift;
                    payload_left_next  = payload_left_reg - 17'd1;
                    if (pay_last)
                    begin
                        push      = 1'b1;
                        item.kind = KIND_BEGUN;
                        item.data = size_shift;
                    end
                end
                PH_CHUNK_PAY:
                begin
                    payload_left_next  = payload_left_reg - 17'd1;
                    transfer_left_next = transfer_left_reg - 32'd1;
                    push      = 1'b1;
                    item.kind = KIND_PAYLOAD;
                    item.data = {24'd0, stream_byte};
                    item.last = (transfer_left_reg == 32'd1);
                end
                PH_IDLE, PH_CHUNK_HDR, PH_END_HDR:
                begin
                    // Shift the byte into its header field, clearing at the first byte
                    if (header_index_reg == 4'd0)
                    begin
                        magic_next   = {24'd0, stream_byte};
                        version_next = 16'd0;
                        type_next    = 16'd0;
                        length_next  = 24'd0;
                    end
                    else if (header_index_reg < 4'd4)
                        magic_next = {magic_reg[23:0], stream_byte};
                    else if (header_index_reg < 4'd6)
                        version_next = {version_reg[7:0], stream_byte};
                    else if (header_index_reg < 4'd8)
                        type_next = {type_reg[7:0], stream_byte};
                    else
                        length_next = {length_reg[15:0], stream_byte};

                    header_index_next = header_index_reg + 4'd1;
                    if (hdr_last)
                    begin
                        header_index_next = 4'd0;
                        if (hdr_err != ERR_NONE)
                        begin
                            // Drop the transfer
                            payload_left_next  = 17'd0;
                            transfer_left_next = 32'd0;
                            push      = 1'b1;
                            item.kind = KIND_ERROR;
                            item.err  = hdr_err;
                        end
                        else if (phase_reg == PH_CHUNK_HDR)
                        begin
                            payload_left_next = length_full[16:0];
                        end
                        else if (phase_reg == PH_END_HDR)
                        begin
                            transfer_left_next = 32'd0;
                            push      = 1'b1;
                            item.kind = KIND_COMPLETE;
                        end
                        else
                        begin
                            payload_left_next  = 17'd4;
                            transfer_left_next = 32'd0;
                        end
                    end
                end
                default:
                begin
                    header_index_next = 4'd0;
                end
            endcase
        end
    end

    // Hold state between items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            header_index_reg  <= 4'd0;
            magic_reg         <= 32'd0;
            version_reg       <= 16'd0;
            type_reg          <= 16'd0;
            length_reg        <= 24'd0;
            payload_left_reg  <= 17'd0;
            transfer_left_reg <= 32'd0;
        end
        else
        begin
            phase_reg         <= phase_next;
            header_index_reg  <= header_index_next;
            magic_reg         <= magic_next;
            version_reg       <= version_next;
            type_reg          <= type_next;
            length_reg        <= length_next;
            payload_left_reg  <= payload_left_next;
            transfer_left_reg <= transfer_left_next;
        end
    end

endmodule

/* rtl/usd_queue.sv */
// Result queue between front end and back end: a small circular buffer.
// Depends on usd_pkg for the item type.
`timescale 1ns / 1ps

module usd_queue #(
    parameter int unsigned DEPTH = usd_pkg::USD_QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  usd_pkg::usd_item_t push_item,
    input  logic               pop,
    output logic               head_valid,
    output usd_pkg::usd_item_t head_item,
    output logic               full
);
    import usd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    usd_item_t        entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_FULL);
    assign head_item  = entries_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed items
    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_item;
    end

endmodule

/* rtl/usd_back.sv */
// Back end: takes items from the queue into the output register and expands them.
// Depends on usd_pkg for the item type and result kinds.
`timescale 1ns / 1ps

module usd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  usd_pkg::usd_item_t head_item,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         result_kind,
    output logic [7:0]         payload_byte,
    output logic               last_of_transfer,
    output logic [31:0]        transfer_size,
    output logic [2:0]         error_code
);
    import usd_pkg::*;

    logic      valid_reg;
    usd_item_t item_reg;

    // Load when the output register is empty or being taken
    assign pop = head_valid && (!valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            item_reg <= head_item;
    end

    // Expand the held item onto the result fields
    assign out_valid        = valid_reg;
    assign result_kind      = item_reg.kind;
    assign payload_byte     = (item_reg.kind == KIND_PAYLOAD) ? item_reg.data[7:0] : 8'd0;
    assign last_of_transfer = (item_reg.kind == KIND_PAYLOAD) ? item_reg.last : 1'b0;
    assign transfer_size    = (item_reg.kind == KIND_BEGUN) ? item_reg.data : 32'd0;
    assign error_code       = (item_reg.kind == KIND_ERROR) ? item_reg.err : ERR_NONE;

endmodule

/* bench/upload_stream_checker.sv */
// Result checker for the upload stream deframer bench: watches both item
// channels and the register port, predicts each result and compares it.
// Depends on usd_pkg for kinds, error codes, register indexes and reset values.
`timescale 1ns / 1ps

module upload_stream_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [7:0]         stream_byte,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [1:0]         result_kind,
    input  logic [7:0]         payload_byte,
    input  logic               last_of_transfer,
    input  logic [31:0]        transfer_size,
    input  logic [2:0]         error_code,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int unsigned        mismatches,
    output int unsigned        outstanding
);
    import usd_pkg::*;

    typedef struct packed {
        usd_kind_t   kind;
        logic [7:0]  data;
        logic        last;
        logic [31:0] size;
        usd_err_t    err;
    } upload_event_t;

    upload_event_t awaited_events[$];

    // Register copies
    logic [31:0] cfg_magic;
    logic [15:0] cfg_version;
    logic [16:0] cfg_max_pay;
    logic [15:0] cfg_type_begin;
    logic [15:0] cfg_type_chunk;
    logic [15:0] cfg_type_end;

    // Deframer state copies
    usd_phase_t  phase;
    logic [3:0]  hdr_count;
    logic [31:0] magic_acc;
    logic [15:0] version_acc;
    logic [15:0] type_acc;
    logic [31:0] length_acc;
    logic [31:0] payload_left;
    logic [31:0] transfer_left;

    // Advance the deframer by one stream byte; return 1 when it yields a result
    function automatic bit deframe_byte(input logic [7:0] b, output upload_event_t ev);
        usd_err_t fault;
        ev = '0;
        fault = ERR_NONE;

        // Gather the announced size from the begin payload
        if (phase == PH_BEGIN_PAY)
        begin
            transfer_left = {transfer_left[23:0], b};
            payload_left -= 1;
            if (payload_left == 0)
            begin
                phase = (transfer_left == 0) ? PH_END_HDR : PH_CHUNK_HDR;
                ev.kind = KIND_BEGUN;
                ev.size = transfer_left;
                return 1'b1;
            end
            return 1'b0;
        end

        // Pass chunk data straight through
        if (phase == PH_CHUNK_PAY)
        begin
            payload_left -= 1;
            transfer_left -= 1;
            if (payload_left == 0)
                phase = (transfer_left == 0) ? PH_END_HDR : PH_CHUNK_HDR;
            ev.kind = KIND_PAYLOAD;
            ev.data = b;
            ev.last = (transfer_left == 0);
            return 1'b1;
        end

        if (phase != PH_CHUNK_HDR && phase != PH_END_HDR)
            phase = PH_IDLE;

        // Shift the header byte into its field
        if (hdr_count == 0)
        begin
            magic_acc   = '0;
            version_acc = '0;
            type_acc    = '0;
            length_acc  = '0;
        end
        if (hdr_count < 4)
            magic_acc = {magic_acc[23:0], b};
        else if (hdr_count < 6)
            version_acc = {version_acc[7:0], b};
        else if (hdr_count < 8)
            type_acc = {type_acc[7:0], b};
        else
            length_acc = {length_acc[23:0], b};
        hdr_count += 1;
        if (hdr_count != USD_HDR_BYTES)
            return 1'b0;

        // Check the full header: common fields first, then the phase rules
        hdr_count = 0;
        if (magic_acc != cfg_magic)
            fault = ERR_MAGIC;
        else if (version_acc != cfg_version)
            fault = ERR_VERSION;
        else if (length_acc > {15'd0, cfg_max_pay})
            fault = ERR_TOO_LONG;
        else if (phase == PH_CHUNK_HDR)
        begin
            if (type_acc != cfg_type_chunk)
                fault = ERR_TYPE;
            else if (length_acc == 0 || length_acc > transfer_left)
                fault = ERR_CHUNK_LEN;
            else
            begin
                payload_left = length_acc;
                phase = PH_CHUNK_PAY;
            end
        end
        else if (phase == PH_END_HDR)
        begin
            if (type_acc != cfg_type_end)
                fault = ERR_TYPE;
            else if (length_acc != 0)
                fault = ERR_END_LEN;
            else
            begin
                phase = PH_IDLE;
                transfer_left = 0;
                ev.kind = KIND_COMPLETE;
                return 1'b1;
            end
        end
        else
        begin
            if (type_acc != cfg_type_begin)
                fault = ERR_TYPE;
            else if (length_acc != 4)
                fault = ERR_BEGIN_LEN;
            else
            begin
                payload_left = 4;
                transfer_left = 0;
                phase = PH_BEGIN_PAY;
            end
        end

        // Drop the transfer on any fault
        if (fault != ERR_NONE)
        begin
            phase = PH_IDLE;
            payload_left = 0;
            transfer_left = 0;
            ev.kind = KIND_ERROR;
            ev.err = fault;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        upload_event_t ev;
        if (!rst_n)
        begin
            cfg_magic      = USD_MAGIC_RESET;
            cfg_version    = USD_VERSION_RESET;
            cfg_max_pay    = USD_MAX_PAY_RESET;
            cfg_type_begin = USD_TYPE_BEGIN_RESET;
            cfg_type_chunk = USD_TYPE_CHUNK_RESET;
            cfg_type_end   = USD_TYPE_END_RESET;
            phase          = PH_IDLE;
            hdr_count      = '0;
            magic_acc      = '0;
            version_acc    = '0;
            type_acc       = '0;
            length_acc     = '0;
            payload_left   = '0;
            transfer_left  = '0;
            awaited_events.delete();
            mismatches     = 0;
            outstanding    = 0;
        end
        else
        begin
            // Compare a delivered result with the oldest expectation
            if (out_valid && out_ready)
            begin
                if (awaited_events.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: expected no result, got kind %0d", $time,
                             result_kind);
                end
                else
                begin
                    ev = awaited_events.pop_front();
                    check_field("result_kind", 32'(ev.kind), 32'(result_kind));
                    check_field("payload_byte", 32'(ev.data), 32'(payload_byte));
                    check_field("last_of_transfer", 32'(ev.last),
                                32'(last_of_transfer));
                    check_field("transfer_size", ev.size, transfer_size);
                    check_field("error_code", 32'(ev.err), 32'(error_code));
                end
            end

            // Track register writes, masked to each register's width
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAGIC:      cfg_magic      = cfg_data;
                    REG_VERSION:    cfg_version    = cfg_data[15:0];
                    REG_MAX_PAY:    cfg_max_pay    = cfg_data[16:0];
                    REG_TYPE_BEGIN: cfg_type_begin = cfg_data[15:0];
                    REG_TYPE_CHUNK: cfg_type_chunk = cfg_data[15:0];
                    REG_TYPE_END:   cfg_type_end   = cfg_data[15:0];
                    default: ;
                endcase
            end

            // Predict the result of an accepted byte
            if (in_valid && in_ready)
            begin
                if (deframe_byte(stream_byte, ev))
                    awaited_events.push_back(ev);
            end
            outstanding = awaited_events.size();
        end
    end

endmodule

/* bench/upload_stream_deframer_test.sv */
// Top of the upload stream deframer bench: clock, reset, byte stream and
// register stimulus, sink stalls and the verdict.
// Depends on usd_pkg, upload_stream_deframer and upload_stream_checker.
`timescale 1ns / 1ps

module upload_stream_deframer_test;
    import usd_pkg::*;

    // Indexes past the register list; writes there are ignored
    localparam logic [2:0]  SPARE_REG_A  = 3'd6;
    localparam logic [2:0]  SPARE_REG_B  = 3'd7;
    localparam int unsigned DRAIN_CYCLES = USD_QUEUE_DEPTH + 8;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    logic        clk              = 1'b0;
    logic        rst_n            = 1'b0;
    logic        in_valid         = 1'b0;
    logic        in_ready;
    logic [7:0]  stream_byte      = 8'd0;
    logic        out_valid;
    logic        out_ready        = 1'b0;
    logic [1:0]  result_kind;
    logic [7:0]  payload_byte;
    logic        last_of_transfer;
    logic [31:0] transfer_size;
    logic [2:0]  error_code;
    logic        cfg_we           = 1'b0;
    logic [2:0]  cfg_index        = 3'd0;
    logic [31:0] cfg_data         = 32'd0;
    int unsigned mismatches;
    int unsigned outstanding;

    // Current register values, used to build well-formed messages
    logic [31:0] magic_val   = USD_MAGIC_RESET;
    logic [15:0] version_val = USD_VERSION_RESET;
    logic [16:0] max_pay_val = USD_MAX_PAY_RESET;
    logic [15:0] type_b_val  = USD_TYPE_BEGIN_RESET;
    logic [15:0] type_c_val  = USD_TYPE_CHUNK_RESET;
    logic [15:0] type_e_val  = USD_TYPE_END_RESET;

    bit          sender_gaps = 1'b0;
    bit          sink_stalls = 1'b0;
    bit          spoil       = 1'b0;
    int unsigned bytes_sent  = 0;
    int unsigned stall_left  = 0;

    upload_stream_deframer dut (.*);
    upload_stream_checker  u_checker (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the result channel in random bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (sink_stalls && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 11);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Offer one byte, with an occasional gap first, and hold it until taken
    task automatic push_byte(input logic [7:0] b);
        if (sender_gaps && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        stream_byte <= b;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    // Send the low bytes of a word, most significant first
    task automatic send_word(input logic [31:0] w, input int count);
        for (int i = count - 1; i >= 0; i--)
            push_byte(w[8*i +: 8]);
    endtask

    // Send a header, now and then with one field damaged
    task automatic send_header(input logic [31:0] m, input logic [15:0] v,
                               input logic [15:0] t, input logic [31:0] len);
        if (spoil && $urandom_range(0, 24) == 0)
        begin
            case ($urandom_range(0, 3))
                0: m ^= 32'd1 << $urandom_range(0, 31);
                1: v ^= 16'd1 << $urandom_range(0, 15);
                2: t ^= 16'd1 << $urandom_range(0, 15);
                default: len += $urandom_range(1, 5);
            endcase
        end
        send_word(m, 4);
        send_word(v, 2);
        send_word(t, 2);
        send_word(len, 4);
    endtask

    // Send a complete transfer: begin, random chunks and end
    task automatic send_transfer(input logic [31:0] size, input int max_chunk);
        logic [31:0] left;
        int          cap;
        int          n;
        send_header(magic_val, version_val, type_b_val, 32'd4);
        send_word(size, 4);
        left = size;
        while (left != 0)
        begin
            cap = max_chunk;
            if (max_pay_val != 0 && int'(max_pay_val) < cap)
                cap = int'(max_pay_val);
            if (left < 32'(cap))
                cap = int'(left);
            n = int'($urandom_range(1, cap));
            send_header(magic_val, version_val, type_c_val, 32'(n));
            repeat (n) push_byte(8'($urandom_range(0, 255)));
            left -= 32'(n);
        end
        send_header(magic_val, version_val, type_e_val, 32'd0);
    endtask

    // Release the stream and wait until every result is in and the block is idle
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [31:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
    endtask

    // Write every register once the block is idle, plus one spare index
    task automatic program_regs(input logic [31:0] m, input logic [31:0] v,
                                input logic [31:0] maxp, input logic [31:0] tb,
                                input logic [31:0] tc, input logic [31:0] te);
        settle();
        put_reg(REG_MAGIC, m);
        put_reg(REG_VERSION, v);
        put_reg(REG_MAX_PAY, maxp);
        put_reg(REG_TYPE_BEGIN, tb);
        put_reg(REG_TYPE_CHUNK, tc);
        put_reg(REG_TYPE_END, te);
        put_reg($urandom_range(0, 1) ? SPARE_REG_A : SPARE_REG_B, $urandom);
        cfg_we      <= 1'b0;
        magic_val   = m;
        version_val = v[15:0];
        max_pay_val = maxp[16:0];
        type_b_val  = tb[15:0];
        type_c_val  = tc[15:0];
        type_e_val  = te[15:0];
    endtask

    // Mostly well-formed transfers with random content, the rest broken
    task automatic random_traffic(input int unsigned budget, input bit calm);
        int unsigned start;
        int          sel;
        start = bytes_sent;
        spoil = 1'b1;
        while (bytes_sent - start < budget)
        begin
            sender_gaps = !calm && $urandom_range(0, 2) != 0;
            sink_stalls = !calm && $urandom_range(0, 2) != 0;
            sel = int'($urandom_range(0, 15));
            if (sel <= 9)
                send_transfer($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 24), 12);
            else if (sel == 10)
            begin
                // huge size, one chunk, then the end header too early
                send_header(magic_val, version_val, type_b_val, 32'd4);
                send_word($urandom, 4);
                send_header(magic_val, version_val, type_c_val, 32'd3);
                repeat (3) push_byte(8'($urandom_range(0, 255)));
                send_header(magic_val, version_val, type_e_val, 32'd0);
            end
            else if (sel <= 12)
                repeat ($urandom_range(1, 16)) push_byte(8'($urandom_range(0, 255)));
            else if (sel == 13)
                send_header(magic_val, version_val, 16'($urandom),
                            32'($urandom_range(0, 8)));
            else
            begin
                // begin only; the next episode breaks into the transfer
                send_header(magic_val, version_val, type_b_val, 32'd4);
                send_word($urandom_range(1, 20), 4);
            end
        end
        spoil = 1'b0;
    endtask

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("** upload_stream_deframer: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases under reset register values
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        send_header(magic_val, version_val, type_b_val, 32'd4);
        send_word(32'd3, 4);
        send_header(magic_val, version_val, type_c_val, 32'd2);
        push_byte(8'h00);
        push_byte(8'hFF);
        send_header(magic_val, version_val, type_c_val, 32'd1);
        push_byte(8'h80);
        send_header(magic_val, version_val, type_e_val, 32'd0);
        // zero size goes straight to the end message
        send_transfer(32'd0, 1);
        // header faults in check order
        send_header(32'hFFFF_FFFF, version_val, type_b_val, 32'd4);
        send_header(magic_val, 16'hFFFF, type_b_val, 32'd4);
        send_header(magic_val, version_val, type_b_val, 32'hFFFF_FFFF);
        send_header(magic_val, version_val, type_b_val, {15'd0, max_pay_val} + 1);
        send_header(magic_val, version_val, type_c_val, 32'd4);
        send_header(magic_val, version_val, type_b_val, 32'd0);
        // begin length fault, then chunk and end header faults inside transfers
        send_header(magic_val, version_val, type_b_val, 32'd5);
        send_header(magic_val, version_val, type_b_val, 32'd4);
        send_word(32'd5, 4);
        send_header(magic_val, version_val, type_c_val, 32'd0);
        send_header(magic_val, version_val, type_b_val, 32'd4);
        send_word(32'd2, 4);
        send_header(magic_val, version_val, type_c_val, 32'd3);
        send_header(magic_val, version_val, type_b_val, 32'd4);
        send_word(32'hFFFF_FFFF, 4);
        send_header(magic_val, version_val, type_c_val, {15'd0, max_pay_val} + 1);
        send_header(magic_val, version_val, type_b_val, 32'd4);
        send_word(32'd1, 4);
        send_header(magic_val, version_val, type_e_val, 32'd1);
        send_header(magic_val, version_val, type_b_val, 32'd4);
        send_word(32'd0, 4);
        send_header(magic_val, version_val, type_c_val, 32'd0);
        send_header(magic_val, version_val, type_b_val, 32'd4);
        send_word(32'd0, 4);
        send_header(magic_val, version_val, type_e_val, 32'd1);
        random_traffic(100, 1'b0);

        // Random registers with a small payload limit
        program_regs($urandom, $urandom, ($urandom & 32'hFFFE_0000) | $urandom_range(1, 48),
                     $urandom, $urandom, $urandom);
        random_traffic(100, 1'b0);

        // All-ones extremes; the payload limit masks to its top value
        program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'h0000_FFFF, 32'h0000_0000, 32'hFFFF_8000);
        send_header(magic_val, version_val, type_b_val, 32'h0001_FFFF);
        send_header(magic_val, version_val, type_b_val, 32'h0002_0000);
        random_traffic(60, 1'b0);

        // All-zero extremes: no payload allowed, every type code the same
        program_regs(32'd0, 32'hFFFF_0000, 32'hFFFE_0000, 32'd0, 32'd0, 32'd0);
        random_traffic(40, 1'b0);

        // A limit of 0x10000, then a final stretch with no idling
        program_regs($urandom, $urandom, 32'h0001_0000, $urandom, $urandom, $urandom);
        send_header(magic_val, version_val, type_b_val, 32'h0001_0000);
        send_header(magic_val, version_val, type_b_val, 32'h0001_0001);
        random_traffic(100, 1'b1);

        settle();
        if (mismatches == 0)
            $display("** upload_stream_deframer: PASSED **");
        else
            $display("** upload_stream_deframer: FAILED **");
        $finish;
    end

endmodule

/* files.f */
rtl/usd_pkg.sv
rtl/usd_front.sv
rtl/usd_queue.sv
rtl/usd_back.sv
rtl/upload_stream_deframer.sv
bench/upload_stream_checker.sv
bench/upload_stream_deframer_test.sv
